### design/vmsa_pkg.sv
// Package for the vector magnitude block: controller states, datapath operations,
// the command and status structs between controller and datapath, and fixed constants.
// No dependencies.
package vmsa_pkg;

  // Polynomial, scaling and rounding constants.
  localparam logic [15:0] POLY_C4    = 16'hA000;
  localparam logic [15:0] POLY_C5    = 16'hB333;
  localparam logic [15:0] INV_SQRT2  = 16'hB505;
  localparam logic [31:0] ROUND_HALF = 32'h0000_8000;

  // Shift amounts of the polynomial terms and of the Newton correction.
  localparam int unsigned POLY_SH1   = 18;
  localparam int unsigned POLY_SH2   = 17;
  localparam int unsigned NEWTON_SH  = 17;

  // Controller states, one per datapath step.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_SUM,
    ST_NRM16,
    ST_NRM8,
    ST_NRM4,
    ST_NRM2,
    ST_NRM1,
    ST_POLY0,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_P5,
    ST_P6,
    ST_EST,
    ST_EST_SQ,
    ST_NEWTON,
    ST_SHIFT,
    ST_SCALE,
    ST_DONE
  } vmsa_state_e;

  // Datapath operations.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_A,
    OP_SQ_B,
    OP_SUM,
    OP_NRM16,
    OP_NRM8,
    OP_NRM4,
    OP_NRM2,
    OP_NRM1,
    OP_POLY0,
    OP_P1,
    OP_P2,
    OP_P3,
    OP_P4,
    OP_P5,
    OP_P6,
    OP_EST,
    OP_EST_SQ,
    OP_NEWTON,
    OP_SHIFT,
    OP_SCALE
  } vmsa_op_e;

  // Command from controller to datapath.
  typedef struct packed {
    vmsa_op_e op;
    logic     load_out;
  } vmsa_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic low_sum;
  } vmsa_status_t;

endpackage

### design/vmsa_datapath.sv
// Datapath of the vector magnitude block: operand registers, one shared signed
// multiplier with a product register, normaliser, polynomial accumulator and result register.
// Depends on vmsa_pkg.
module vmsa_datapath import vmsa_pkg::*; (
  input  logic                clk_i,
  input  vmsa_cmd_t           cmd_i,
  input  logic signed [31:0]  comp_a_i,
  input  logic signed [31:0]  comp_b_i,
  output vmsa_status_t        status_o,
  output logic        [15:0]  magnitude_o
);

  logic signed [23:0] a_q, b_q;
  logic        [31:0] prod_q;
  logic        [31:0] norm_q;
  logic        [4:0]  cnt_q;
  logic        [15:0] c_q;
  logic        [15:0] acc_q;
  logic        [15:0] est_q;
  logic        [15:0] magnitude_q;

  logic signed [24:0] mul_x, mul_y;
  logic signed [49:0] mul_p;
  logic        [15:0] t_sh1, t_sh2, t_hi;
  logic        [31:0] resid;
  logic signed [31:0] resid_sh;
  logic        [15:0] rounded;
  logic        [15:0] res;

  function automatic logic signed [24:0] zext16(input logic [15:0] v);
    return $signed({9'd0, v});
  endfunction

  // Terms taken from the product register.
  assign t_sh1 = 16'(prod_q >> POLY_SH1);
  assign t_sh2 = 16'(prod_q >> POLY_SH2);
  assign t_hi  = prod_q[31:16];

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (cmd_i.op)
      OP_SQ_A: begin
        mul_x = {a_q[23], a_q};
        mul_y = {a_q[23], a_q};
      end
      OP_SQ_B: begin
        mul_x = {b_q[23], b_q};
        mul_y = {b_q[23], b_q};
      end
      OP_P1: begin
        mul_x = zext16({1'b0, c_q[15:1]});
        mul_y = zext16(c_q);
      end
      OP_P2: begin
        mul_x = zext16(t_sh1);
        mul_y = zext16(c_q);
      end
      OP_P3: begin
        mul_x = zext16(t_sh2);
        mul_y = zext16(c_q);
      end
      OP_P4: begin
        mul_x = zext16(t_hi);
        mul_y = zext16(POLY_C4);
      end
      OP_P5: begin
        mul_x = zext16(t_hi);
        mul_y = zext16(c_q);
      end
      OP_P6: begin
        mul_x = zext16(t_hi);
        mul_y = zext16(POLY_C5);
      end
      OP_EST_SQ: begin
        mul_x = zext16(est_q);
        mul_y = zext16(est_q);
      end
      OP_SCALE: begin
        mul_x = zext16(est_q);
        mul_y = zext16(INV_SQRT2);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p = mul_x * mul_y;

  // Newton residual, read as signed and shifted arithmetically.
  assign resid    = norm_q - prod_q;
  assign resid_sh = $signed(resid) >>> NEWTON_SH;

  // Final value: small sums pass through, odd counts are scaled with rounding.
  assign rounded = 16'((prod_q + ROUND_HALF) >> 16);

  always_comb begin
    if (status_o.low_sum) begin
      res = norm_q[15:0];
    end else if (cnt_q[0]) begin
      res = rounded;
    end else begin
      res = est_q;
    end
  end

  assign status_o.low_sum = (norm_q[31:1] == 31'd0);

  // Datapath registers, updated by the operation of the cycle.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        a_q <= comp_a_i[31:8];
        b_q <= comp_b_i[31:8];
      end
      OP_SQ_A: begin
        prod_q <= mul_p[31:0];
      end
      OP_SQ_B: begin
        norm_q <= prod_q;
        prod_q <= mul_p[31:0];
      end
      OP_SUM: begin
        norm_q <= norm_q + prod_q;
        cnt_q  <= '0;
      end
      OP_NRM16: begin
        if (norm_q[31:16] == 16'd0) begin
          norm_q <= {norm_q[15:0], 16'd0};
          cnt_q  <= cnt_q + 5'd16;
        end
      end
      OP_NRM8: begin
        if (norm_q[31:24] == 8'd0) begin
          norm_q <= {norm_q[23:0], 8'd0};
          cnt_q  <= cnt_q + 5'd8;
        end
      end
      OP_NRM4: begin
        if (norm_q[31:28] == 4'd0) begin
          norm_q <= {norm_q[27:0], 4'd0};
          cnt_q  <= cnt_q + 5'd4;
        end
      end
      OP_NRM2: begin
        if (norm_q[31:30] == 2'd0) begin
          norm_q <= {norm_q[29:0], 2'd0};
          cnt_q  <= cnt_q + 5'd2;
        end
      end
      OP_NRM1: begin
        if (!norm_q[31]) begin
          norm_q <= {norm_q[30:0], 1'b0};
          cnt_q  <= cnt_q + 5'd1;
        end
      end
      OP_POLY0: begin
        c_q   <= ~norm_q[31:16];
        acc_q <= {1'b0, ~norm_q[31:17]};
      end
      OP_P1: begin
        prod_q <= mul_p[31:0];
      end
      OP_P2: begin
        acc_q  <= acc_q + t_sh1;
        prod_q <= mul_p[31:0];
      end
      OP_P3: begin
        acc_q  <= acc_q + t_sh2;
        prod_q <= mul_p[31:0];
      end
      OP_P4: begin
        prod_q <= mul_p[31:0];
      end
      OP_P5: begin
        acc_q  <= acc_q + t_hi;
        prod_q <= mul_p[31:0];
      end
      OP_P6: begin
        prod_q <= mul_p[31:0];
      end
      OP_EST: begin
        est_q <= ~(acc_q + t_hi);
      end
      OP_EST_SQ: begin
        prod_q <= mul_p[31:0];
      end
      OP_NEWTON: begin
        est_q <= est_q + resid_sh[15:0];
      end
      OP_SHIFT: begin
        est_q <= est_q >> cnt_q[4:1];
      end
      OP_SCALE: begin
        prod_q <= mul_p[31:0];
      end
      default: begin
      end
    endcase
  end

  // Output register, loaded when the controller hands over a finished item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      magnitude_q <= res;
    end
  end

  assign magnitude_o = magnitude_q;

endmodule

### design/vmsa_ctrl.sv
// Controller of the vector magnitude block: sequences the datapath one step per
// cycle (waiting in ST_DONE while the output is full) and runs both handshakes.
// Holds the output valid flag. Depends on vmsa_pkg.
module vmsa_ctrl import vmsa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  vmsa_status_t status_i,
  output vmsa_cmd_t    cmd_o
);

  vmsa_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // The output register may be loaded when empty or emptying in this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SQ_A;
      ST_SQ_A:   state_d = ST_SQ_B;
      ST_SQ_B:   state_d = ST_SUM;
      ST_SUM:    state_d = ST_NRM16;
      ST_NRM16:  state_d = status_i.low_sum ? ST_DONE : ST_NRM8;
      ST_NRM8:   state_d = ST_NRM4;
      ST_NRM4:   state_d = ST_NRM2;
      ST_NRM2:   state_d = ST_NRM1;
      ST_NRM1:   state_d = ST_POLY0;
      ST_POLY0:  state_d = ST_P1;
      ST_P1:     state_d = ST_P2;
      ST_P2:     state_d = ST_P3;
      ST_P3:     state_d = ST_P4;
      ST_P4:     state_d = ST_P5;
      ST_P5:     state_d = ST_P6;
      ST_P6:     state_d = ST_EST;
      ST_EST:    state_d = ST_EST_SQ;
      ST_EST_SQ: state_d = ST_NEWTON;
      ST_NEWTON: state_d = ST_SHIFT;
      ST_SHIFT:  state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath and the input stall.
  always_comb begin
    cmd_o.op       = OP_NONE;
    cmd_o.load_out = 1'b0;
    in_stall_o     = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.op   = in_valid_i ? OP_LOAD : OP_NONE;
      end
      ST_SQ_A:   cmd_o.op = OP_SQ_A;
      ST_SQ_B:   cmd_o.op = OP_SQ_B;
      ST_SUM:    cmd_o.op = OP_SUM;
      ST_NRM16:  cmd_o.op = status_i.low_sum ? OP_NONE : OP_NRM16;
      ST_NRM8:   cmd_o.op = OP_NRM8;
      ST_NRM4:   cmd_o.op = OP_NRM4;
      ST_NRM2:   cmd_o.op = OP_NRM2;
      ST_NRM1:   cmd_o.op = OP_NRM1;
      ST_POLY0:  cmd_o.op = OP_POLY0;
      ST_P1:     cmd_o.op = OP_P1;
      ST_P2:     cmd_o.op = OP_P2;
      ST_P3:     cmd_o.op = OP_P3;
      ST_P4:     cmd_o.op = OP_P4;
      ST_P5:     cmd_o.op = OP_P5;
      ST_P6:     cmd_o.op = OP_P6;
      ST_EST:    cmd_o.op = OP_EST;
      ST_EST_SQ: cmd_o.op = OP_EST_SQ;
      ST_NEWTON: cmd_o.op = OP_NEWTON;
      ST_SHIFT:  cmd_o.op = OP_SHIFT;
      ST_SCALE:  cmd_o.op = OP_SCALE;
      ST_DONE:   cmd_o.load_out = out_free;
      default: begin
        cmd_o.op   = OP_NONE;
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Output valid flag: set on load, cleared when the item is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### design/vector_magnitude_sqrt_approx.sv
// Top level of the vector magnitude block: joins the controller and the datapath.
// Depends on vmsa_pkg, vmsa_ctrl and vmsa_datapath.
//
// Usage:
// An input item carries two signed 32-bit components, comp_a_i and comp_b_i. It is
// taken at a rising edge where in_valid_i is high and in_stall_o is low. The result
// item is the 16-bit approximate root of the sum of the squared components, after
// each has been shifted right by eight.
// The block works on one item at a time. Products go through one shared multiplier
// and a product register, with a five-step leading-zero search for the normaliser.
// The result is loaded into the output register in the last step; when the sum of
// squares is 0 or 1 the block goes there straight from the first normaliser step.
// A new item is taken only after the result is loaded.
// The result sits in an output register: while the receiver holds out_stall_i high
// the item and out_valid_o are held, and the next input item may still be taken
// and worked on; it then waits in its last step until the register is free.
// Reset clears the controller and the output valid flag; an item in work is dropped and none is shown.
module vector_magnitude_sqrt_approx import vmsa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] comp_a_i,
  input  logic signed [31:0] comp_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [15:0] magnitude_o
);

  vmsa_cmd_t    cmd;
  vmsa_status_t status;

  // Step sequencer and handshakes.
  vmsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic and result register.
  vmsa_datapath u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .comp_a_i    (comp_a_i),
    .comp_b_i    (comp_b_i),
    .status_o    (status),
    .magnitude_o (magnitude_o)
  );

endmodule

### design/vmsa_checker.sv
// Port-level checks for the vector magnitude block, attached by a bind statement.
// Depends on vector_magnitude_sqrt_approx.
module vmsa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] magnitude_o
);

  // No result item is shown in the cycle after reset is seen.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // A stalled result item stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result item dropped");

  // A stalled result item keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(magnitude_o))
    else $error("stalled result item changed");

  // Once an item is taken the block raises in_stall_o and holds it over its first steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 in_stall_o)
    else $error("block idle too early after taking an item");

endmodule

bind vector_magnitude_sqrt_approx vmsa_checker u_vmsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .magnitude_o (magnitude_o)
);

### verif/vector_magnitude_sqrt_approx_tb.sv
// Self-checking testbench for vector_magnitude_sqrt_approx: random and corner-case vectors,
// random idling on both channels, and results checked in order against a local root predictor.
// Depends on the block vector_magnitude_sqrt_approx and the RTL beneath it.
module vector_magnitude_sqrt_approx_tb;

  // Run length and watchdog.
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;

  // Constants of the root approximation.
  localparam logic [31:0] C4_COEF   = 32'h0000_A000;
  localparam logic [31:0] C5_COEF   = 32'h0000_B333;
  localparam logic [31:0] RECIP_RT2 = 32'h0000_B505;
  localparam logic [31:0] RND_HALF  = 32'h0000_8000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [31:0] comp_a_i;
  logic signed [31:0] comp_b_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic        [15:0] magnitude_o;

  int unsigned cycle_count;
  int unsigned stall_hold;
  bit          idle_on;

  // Keeps the expected magnitudes in arrival order and counts mismatches.
  class magnitude_scoreboard;
    logic [15:0] expected_mags[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Approximate root of the wrapped sum of squares of the scaled components.
    function automatic logic [15:0] hypot_root(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [31:0] sh_a;
      logic signed [31:0] sh_b;
      logic        [31:0] sum;
      logic        [31:0] norm;
      logic        [31:0] c;
      logic        [31:0] t;
      logic        [31:0] acc;
      logic        [31:0] est;
      logic        [31:0] resid;
      logic signed [31:0] corr;
      int unsigned        count;
      int unsigned        half;
      sh_a = a >>> 8;
      sh_b = b >>> 8;
      sum  = 32'(sh_a * sh_a) + 32'(sh_b * sh_b);
      if (sum == 32'd0 || sum == 32'd1) begin
        return sum[15:0];
      end
      // Normalise until the top bit is set.
      norm  = sum;
      count = 0;
      while (norm[31] == 1'b0) begin
        norm  = norm << 1;
        count = count + 1;
      end
      // Polynomial in the complemented top half.
      c   = {16'h0000, ~norm[31:16]};
      t   = c >> 1;
      acc = t & 32'hFFFF;
      t   = (t * c) >> 18;
      acc = (acc + t) & 32'hFFFF;
      t   = (t * c) >> 17;
      acc = (acc + t) & 32'hFFFF;
      t   = (t * c) >> 16;
      t   = ((t * C4_COEF) >> 16) & 32'hFFFF;
      acc = (acc + t) & 32'hFFFF;
      t   = ((t * c) >> 16) & 32'hFFFF;
      t   = ((t * C5_COEF) >> 16) & 32'hFFFF;
      acc = (acc + t) & 32'hFFFF;
      // One Newton step on the signed residual.
      est   = acc ^ 32'hFFFF;
      resid = norm - est * est;
      corr  = $signed(resid) >>> 17;
      est   = (est + corr) & 32'hFFFF;
      // Undo the normalisation.
      half = count >> 1;
      if (count[0]) begin
        est = (((est >> half) * RECIP_RT2 + RND_HALF) >> 16) & 32'hFFFF;
      end else begin
        est = est >> half;
      end
      return est[15:0];
    endfunction

    function void note_input(logic signed [31:0] a, logic signed [31:0] b);
      expected_mags.push_back(hypot_root(a, b));
    endfunction

    function void check_result(logic [15:0] got);
      logic [15:0] want;
      if (expected_mags.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors = errors + 1;
      end else begin
        want = expected_mags.pop_front();
        if (got !== want) begin
          $display("%0t: magnitude expected %h, actual %h", $time, want, got);
          errors = errors + 1;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_mags.size();
    endfunction
  endclass

  magnitude_scoreboard board;

  vector_magnitude_sqrt_approx i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .comp_a_i    (comp_a_i),
    .comp_b_i    (comp_b_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .magnitude_o (magnitude_o)
  );

  // Clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("vector_magnitude_sqrt_approx: mismatch");
      $finish;
    end
  end

  // Receiver stalls: mostly short, a few long, none while idling is off.
  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (!idle_on || $urandom_range(0, 3) != 0) begin
      out_stall_i <= 1'b0;
      stall_hold  <= $urandom_range(0, 6);
    end else begin
      out_stall_i <= 1'b1;
      stall_hold  <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 3);
    end
  end

  // Monitor both channels at the clock edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        board.note_input(comp_a_i, comp_b_i);
      end
      if (out_valid_o && !out_stall_i) begin
        board.check_result(magnitude_o);
      end
    end
  end

  // Gap before the next item: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (!idle_on || r < 12) begin
      return 0;
    end else if (r < 18) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 60);
  endfunction

  // Random component: full range, small and medium magnitudes, or near the extremes.
  function automatic logic [31:0] random_component();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(8, 31);
      2: v = $urandom & ((32'd1 << $urandom_range(9, 24)) - 1);
      default: v = 32'h7FFF_FFFF ^ ($urandom & 32'h0000_0FFF);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      v = -v;
    end
    return v;
  endfunction

  // Present one item and hold it until it is taken.
  task automatic send_vector(logic [31:0] a, logic [31:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    comp_a_i   <= a;
    comp_b_i   <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  initial begin
    board       = new();
    cycle_count = 0;
    stall_hold  = 0;
    idle_on     = 1'b1;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    comp_a_i    = '0;
    comp_b_i    = '0;
    out_stall_i = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: sums of zero and one, small even and odd shift counts,
    // a sum that is already normalised, wrapping squares and sums, and extremes.
    send_vector(32'h0000_0000, 32'h0000_0000);
    send_vector(32'h0000_00FF, 32'hFFFF_FF01);
    send_vector(32'h0000_0100, 32'h0000_0000);
    send_vector(32'hFFFF_FFFF, 32'h0000_0000);
    send_vector(32'h0000_0000, 32'hFFFF_FF00);
    send_vector(32'h0000_0100, 32'h0000_0100);
    send_vector(32'h0000_0100, 32'h0000_0180);
    send_vector(32'h0000_0200, 32'h0000_0000);
    send_vector(32'h0000_0200, 32'h0000_0100);
    send_vector(32'h0000_0300, 32'h0000_0000);
    send_vector(32'h0001_0000, 32'h0000_0000);
    send_vector(32'h0080_0000, 32'h0000_0000);
    send_vector(32'h00B5_0500, 32'h0000_0000);
    send_vector(32'hFF4A_FB00, 32'h0001_0000);
    send_vector(32'h00FF_FF00, 32'h00FF_FF00);
    send_vector(32'h7FFF_0000, 32'h0000_0000);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vector(32'h8000_0000, 32'h8000_0000);
    send_vector(32'h7FFF_FFFF, 32'h8000_0000);
    send_vector(32'h8000_0000, 32'h0000_0000);
    send_vector(32'h1234_5678, 32'h9ABC_DEF0);
    send_vector(32'h0000_FFFF, 32'hFFFF_0001);
    send_vector(32'h5555_5555, 32'hAAAA_AAAA);

    // Random phases; one of them runs without idling on either side.
    for (int phase = 0; phase < 4; phase++) begin
      idle_on = (phase != 1);
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        send_vector(random_component(), random_component());
      end
    end
    in_valid_i <= 1'b0;
    idle_on = 1'b1;

    // Drain, then allow time for any stray result.
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("vector_magnitude_sqrt_approx: match");
    end else begin
      $display("vector_magnitude_sqrt_approx: mismatch");
    end
    $finish;
  end

endmodule
